// ----- src/assert_macros.svh -----
// Assertion macros shared by the cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk_i outside reset.
`define LKV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lkv assertion failed");

// Condition that must never hold outside reset.
`define LKV_ASSERT_NEVER(lbl, cond) \
  `LKV_ASSERT(lbl, !(cond))

`endif

// ----- src/lkv_pkg.sv -----
// Shared types and constants for the LRU key/value cache.
`timescale 1ns / 1ps
package lkv_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CAP_W   = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [0:0] {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_e;

endpackage

// ----- src/lru_key_value_cache.sv -----
// Fully associative key/value cache with LRU replacement, built as a recency chain.
// A transfer's result is held in the output register from the next cycle on.
// Throughput: one get or put per cycle while no held result waits; the limit is the
// combinational parallel key compare over all MaxEntries cells and the chain shift.
// Reset: asynchronous, active low; cache empty, capacity register at 16.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int MaxEntries = 16,
  parameter int KeyBits    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // capacity register
  input  logic               capacity_we_i,
  input  logic [CAP_W-1:0]   capacity_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [0:0]         func_i,
  input  logic [KeyBits-1:0] key_i,
  input  logic [VALUE_W-1:0] value_i,
  // response channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [VALUE_W-1:0] read_value_o
);

  localparam int CntW = $clog2(MaxEntries + 1);
  localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CmpW = (CntW > int'(CAP_W)) ? CntW : int'(CAP_W);

  // Cell 0 is the most recent entry; valid cells always fill 0..count-1.
  logic [MaxEntries-1:0] cell_valid;
  logic [MaxEntries-1:0] cell_match;
  logic [MaxEntries-1:0] cell_shift;
  logic [KeyBits-1:0]    cell_key   [MaxEntries];
  logic [VALUE_W-1:0]    cell_value [MaxEntries];

  logic [CAP_W-1:0]   cap_q;
  logic [CntW-1:0]    count_q, count_d;
  logic               out_valid_q;
  logic               found_q;
  logic [VALUE_W-1:0] read_value_q;

  logic               in_xfer;
  logic               is_put;
  logic               hit;
  logic [IdxW-1:0]    hit_idx;
  logic [VALUE_W-1:0] hit_value;
  logic [CmpW-1:0]    eff_cap;
  logic               need_evict;
  logic [CntW-1:0]    move_pos;
  logic [VALUE_W-1:0] head_value;

  // Output register decouples the two sides: a new transfer is taken while the
  // held result is being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_put     = (func_e'(func_i) == FUNC_PUT);

  // Keys are unique in the chain, so the match vector is one-hot or empty and
  // index and value can be gathered by OR.
  always_comb begin
    hit_idx   = '0;
    hit_value = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      if (cell_match[i]) begin
        hit_idx   = hit_idx | IdxW'(i);
        hit_value = hit_value | cell_value[i];
      end
    end
  end
  assign hit = |cell_match;

  // Capacity of zero acts as one; above the cell count it saturates.
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CmpW'(1);
    end else if (CmpW'(cap_q) > CmpW'(MaxEntries)) begin
      eff_cap = CmpW'(MaxEntries);
    end else begin
      eff_cap = CmpW'(cap_q);
    end
  end
  assign need_evict = CmpW'(count_q) >= eff_cap;

  // Every operation that changes order is "move cell move_pos to the front":
  // a hit moves the hit cell, an insert overwrites the oldest on eviction or
  // pulls in the first free cell otherwise.
  always_comb begin
    if (hit) begin
      move_pos = CntW'(hit_idx);
    end else if (need_evict) begin
      move_pos = count_q - CntW'(1);
    end else begin
      move_pos = count_q;
    end
  end

  always_comb begin
    for (int i = 0; i < MaxEntries; i++) begin
      cell_shift[i] = in_xfer && (hit || is_put) && (CntW'(i) <= move_pos);
    end
  end

  assign head_value = is_put ? value_i : hit_value;

  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    if (g == 0) begin : g_head
      lkv_cell #(.KeyBits(KeyBits)) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .shift_i      (cell_shift[g]),
        .prev_valid_i (1'b1),
        .prev_key_i   (key_i),
        .prev_value_i (head_value),
        .lookup_key_i (key_i),
        .valid_o      (cell_valid[g]),
        .key_o        (cell_key[g]),
        .value_o      (cell_value[g]),
        .match_o      (cell_match[g])
      );
    end else begin : g_body
      lkv_cell #(.KeyBits(KeyBits)) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .shift_i      (cell_shift[g]),
        .prev_valid_i (cell_valid[g-1]),
        .prev_key_i   (cell_key[g-1]),
        .prev_value_i (cell_value[g-1]),
        .lookup_key_i (key_i),
        .valid_o      (cell_valid[g]),
        .key_o        (cell_key[g]),
        .value_o      (cell_value[g]),
        .match_o      (cell_match[g])
      );
    end
  end

  // Only an insert into a free cell grows the count; eviction keeps it level.
  always_comb begin
    count_d = count_q;
    if (in_xfer && is_put && !hit && !need_evict) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (capacity_we_i) begin
        cap_q <= capacity_i;
      end
      count_q <= count_d;
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      found_q      <= hit;
      read_value_q <= (hit && !is_put) ? hit_value : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign read_value_o = read_value_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  logic [MaxEntries-1:0] count_therm;
  always_comb begin
    for (int i = 0; i < MaxEntries; i++) begin
      count_therm[i] = (CntW'(i) < count_q);
    end
  end

  `LKV_ASSERT_NEVER(a_count_max, count_q > CntW'(MaxEntries))
  `LKV_ASSERT(a_valid_packed, cell_valid == count_therm)
  `LKV_ASSERT(a_unique_keys, $onehot0(cell_match))
  `LKV_ASSERT(a_xfer_result, in_xfer |=> out_valid_q)

endmodule

// ----- src/lkv_cell.sv -----
// One entry of the recency-ordered chain: holds a key/value pair and shifts it on.
`timescale 1ns / 1ps
module lkv_cell import lkv_pkg::*; #(
  parameter int KeyBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic                prev_valid_i,
  input  logic [KeyBits-1:0]  prev_key_i,
  input  logic [VALUE_W-1:0]  prev_value_i,
  input  logic [KeyBits-1:0]  lookup_key_i,
  output logic                valid_o,
  output logic [KeyBits-1:0]  key_o,
  output logic [VALUE_W-1:0]  value_o,
  output logic                match_o
);

  logic               valid_q;
  logic [KeyBits-1:0] key_q;
  logic [VALUE_W-1:0] value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= prev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q   <= prev_key_i;
      value_q <= prev_value_i;
    end
  end

  assign match_o = valid_q && (key_q == lookup_key_i);
  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign value_o = value_q;

endmodule
